[hdl/stb_pkg.sv]
// Shared types and constants for the prescaled timer bank.
// Holds payload structs, command and status codes, and the back-end state type.
// No dependencies.
package stb_pkg;

	localparam int NUM_TIMERS   = 8;
	localparam int MAX_RESULTS  = 8;
	localparam int SLOT_W       = 3;
	localparam int PERIOD_W     = 16;
	localparam int DIV_W        = 8;
	localparam int NREP_W       = 4;
	localparam int DIV_STEPS    = PERIOD_W;
	localparam int STEP_W       = 4;
	localparam logic [DIV_W-1:0] DIVIDER_RESET = 8'd20;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	localparam logic EV_STATUS = 1'b0;
	localparam logic EV_EXPIRY = 1'b1;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [SLOT_W-1:0]   timer_index;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
	} in_t;

	typedef struct packed {
		logic              event_kind;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        status;
		logic              last;
	} out_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_SET,
		OP_START,
		OP_STOP,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [SLOT_W-1:0]   idx;
		logic [PERIOD_W-1:0] period;
		logic                periodic;
	} item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] count;
		logic                periodic;
		logic                enabled;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_SETW,
		S_SCAN,
		S_FLUSH
	} state_t;

endpackage

[hdl/stb_front.sv]
// Front end: accepts input transfers and classifies them into work items.
// Holds one classified item until the queue takes it. Depends on stb_pkg.
module stb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stb_pkg::in_t   in_data,
	output logic           push,
	output stb_pkg::item_t push_item,
	input  logic           q_full
);

	logic           hold_v_q;
	stb_pkg::item_t hold_q;
	stb_pkg::item_t cls;

	always_comb begin
		cls.idx      = in_data.timer_index;
		cls.period   = in_data.period;
		cls.periodic = in_data.periodic;
		cls.op       = stb_pkg::OP_NOP;
		unique case (in_data.cmd)
			stb_pkg::CMD_TICK: cls.op = stb_pkg::OP_TICK;
			stb_pkg::CMD_SET: begin
				if (int'(in_data.timer_index) < stb_pkg::NUM_TIMERS) cls.op = stb_pkg::OP_SET;
			end
			stb_pkg::CMD_START: begin
				if (int'(in_data.timer_index) < stb_pkg::NUM_TIMERS) cls.op = stb_pkg::OP_START;
			end
			stb_pkg::CMD_STOP: begin
				if (int'(in_data.timer_index) < stb_pkg::NUM_TIMERS) cls.op = stb_pkg::OP_STOP;
			end
			default: cls.op = stb_pkg::OP_NOP;
		endcase
	end

	assign push      = hold_v_q && !q_full;
	assign push_item = hold_q;
	assign in_ready  = !hold_v_q || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_v_q <= 1'b1;
		end else if (push) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_q <= cls;
		end
	end

endmodule

[hdl/stb_queue.sv]
// Two-entry queue of classified items between front and back ends.
// Depends on stb_pkg.
module stb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stb_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output stb_pkg::item_t head
);

	stb_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hdl/stb_back.sv]
// Back end: executes items against the slot bank, scans slots on timer ticks,
// divides requested periods bit-serially, and owns the result register.
// Depends on stb_pkg.
module stb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [stb_pkg::DIV_W-1:0]   tick_divider,
	input  logic                        q_valid,
	input  stb_pkg::item_t              q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output stb_pkg::out_t               out_data
);

	stb_pkg::state_t state_q, state_d;
	stb_pkg::item_t  cur_q;
	stb_pkg::slot_t  slots_q [stb_pkg::NUM_TIMERS];

	logic [stb_pkg::DIV_W-1:0]    prescale_q, prescale_d;
	logic [stb_pkg::SLOT_W-1:0]   scan_q, scan_d;
	logic                         pend_v_q, pend_v_d;
	logic [stb_pkg::SLOT_W-1:0]   pend_slot_q, pend_slot_d;
	logic [stb_pkg::NREP_W-1:0]   nrep_q, nrep_d;

	logic [stb_pkg::PERIOD_W-1:0] dividend_q, quot_q;
	logic [stb_pkg::DIV_W-1:0]    rem_q;
	logic [stb_pkg::STEP_W-1:0]   step_q;
	logic                         div_start;
	logic [stb_pkg::DIV_W:0]      shifted;
	logic                         ge;

	logic                         out_valid_q;
	stb_pkg::out_t                out_q;
	logic                         emit;
	logic                         emit_ok;
	stb_pkg::out_t                emit_d;

	logic [stb_pkg::SLOT_W-1:0]   addr;
	stb_pkg::slot_t               rd_rec, wr_rec;
	logic                         wr_en;
	logic [stb_pkg::DIV_W-1:0]    div_eff;
	logic [stb_pkg::PERIOD_W-1:0] dec;
	logic                         expire, report, stall;

	assign div_eff   = (tick_divider == '0) ? stb_pkg::DIV_W'(1) : tick_divider;
	assign addr      = (state_q == stb_pkg::S_SCAN) ? scan_q : cur_q.idx;
	assign rd_rec    = slots_q[addr];
	assign emit_ok   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign shifted = {rem_q, dividend_q[stb_pkg::PERIOD_W-1]};
	assign ge      = shifted >= {1'b0, div_eff};

	always_comb begin
		dec    = rd_rec.count - stb_pkg::PERIOD_W'(1);
		expire = rd_rec.enabled && (dec == '0);
		report = expire && (nrep_q < stb_pkg::NREP_W'(stb_pkg::MAX_RESULTS));
		stall  = report && pend_v_q && !emit_ok;
	end

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		emit        = 1'b0;
		emit_d      = '0;
		wr_en       = 1'b0;
		wr_rec      = rd_rec;
		prescale_d  = prescale_q;
		scan_d      = scan_q;
		pend_v_d    = pend_v_q;
		pend_slot_d = pend_slot_q;
		nrep_d      = nrep_q;
		div_start   = 1'b0;
		emit_d.event_kind = stb_pkg::EV_STATUS;
		emit_d.slot       = cur_q.idx;
		emit_d.status     = stb_pkg::ST_OK;
		emit_d.last       = 1'b1;
		unique case (state_q)
			stb_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = stb_pkg::S_EXEC;
				end
			end
			stb_pkg::S_EXEC: begin
				unique case (cur_q.op)
					stb_pkg::OP_TICK: begin
						if ({1'b0, prescale_q} + 9'd1 >= {1'b0, div_eff}) begin
							prescale_d = '0;
							scan_d     = '0;
							pend_v_d   = 1'b0;
							nrep_d     = '0;
							state_d    = stb_pkg::S_SCAN;
						end else begin
							prescale_d = prescale_q + stb_pkg::DIV_W'(1);
							state_d    = stb_pkg::S_IDLE;
						end
					end
					stb_pkg::OP_SET: begin
						if (rd_rec.enabled) begin
							emit          = 1'b1;
							emit_d.status = stb_pkg::ST_BUSY;
							if (emit_ok) state_d = stb_pkg::S_IDLE;
						end else begin
							div_start = 1'b1;
							state_d   = stb_pkg::S_DIV;
						end
					end
					stb_pkg::OP_START: begin
						emit = 1'b1;
						if (rd_rec.enabled) begin
							wr_rec.count = rd_rec.period;
						end else if (rd_rec.period == '0) begin
							emit_d.status = stb_pkg::ST_ZERO;
						end else begin
							if (rd_rec.count == '0) wr_rec.count = rd_rec.period;
							wr_rec.enabled = 1'b1;
						end
						if (emit_ok) begin
							wr_en   = 1'b1;
							state_d = stb_pkg::S_IDLE;
						end
					end
					stb_pkg::OP_STOP: begin
						emit           = 1'b1;
						wr_rec.enabled = 1'b0;
						if (emit_ok) begin
							wr_en   = 1'b1;
							state_d = stb_pkg::S_IDLE;
						end
					end
					stb_pkg::OP_NOP: begin
						emit = 1'b1;
						if (emit_ok) state_d = stb_pkg::S_IDLE;
					end
					default: state_d = stb_pkg::S_IDLE;
				endcase
			end
			stb_pkg::S_DIV: begin
				if (step_q == stb_pkg::STEP_W'(stb_pkg::DIV_STEPS - 1)) state_d = stb_pkg::S_SETW;
			end
			stb_pkg::S_SETW: begin
				emit = 1'b1;
				if (quot_q == '0) begin
					emit_d.status = stb_pkg::ST_ZERO;
				end else begin
					wr_rec.period   = quot_q;
					wr_rec.count    = quot_q;
					wr_rec.periodic = cur_q.periodic;
				end
				if (emit_ok) begin
					wr_en   = (quot_q != '0);
					state_d = stb_pkg::S_IDLE;
				end
			end
			stb_pkg::S_SCAN: begin
				emit              = report && pend_v_q;
				emit_d.event_kind = stb_pkg::EV_EXPIRY;
				emit_d.slot       = pend_slot_q;
				emit_d.last       = 1'b0;
				if (rd_rec.enabled) begin
					wr_rec.count = expire ? rd_rec.period : dec;
					if (expire && !rd_rec.periodic) wr_rec.enabled = 1'b0;
				end
				if (!stall) begin
					wr_en  = rd_rec.enabled;
					scan_d = scan_q + stb_pkg::SLOT_W'(1);
					if (report) begin
						pend_v_d    = 1'b1;
						pend_slot_d = scan_q;
						nrep_d      = nrep_q + stb_pkg::NREP_W'(1);
					end
					if (scan_q == stb_pkg::SLOT_W'(stb_pkg::NUM_TIMERS - 1)) begin
						state_d = stb_pkg::S_FLUSH;
					end
				end
			end
			stb_pkg::S_FLUSH: begin
				emit_d.event_kind = stb_pkg::EV_EXPIRY;
				emit_d.slot       = pend_slot_q;
				emit_d.last       = 1'b1;
				if (pend_v_q) begin
					emit = 1'b1;
					if (emit_ok) begin
						pend_v_d = 1'b0;
						state_d  = stb_pkg::S_IDLE;
					end
				end else begin
					state_d = stb_pkg::S_IDLE;
				end
			end
			default: state_d = stb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stb_pkg::S_IDLE;
			prescale_q  <= '0;
			scan_q      <= '0;
			pend_v_q    <= 1'b0;
			pend_slot_q <= '0;
			nrep_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			prescale_q  <= prescale_d;
			scan_q      <= scan_d;
			pend_v_q    <= pend_v_d;
			pend_slot_q <= pend_slot_d;
			nrep_q      <= nrep_d;
			if (emit && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr_en) begin
			slots_q[addr] <= wr_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_head;
		if (emit && emit_ok) out_q <= emit_d;
		if (div_start) begin
			dividend_q <= cur_q.period;
			quot_q     <= '0;
			rem_q      <= '0;
			step_q     <= '0;
		end else if (state_q == stb_pkg::S_DIV) begin
			dividend_q <= {dividend_q[stb_pkg::PERIOD_W-2:0], 1'b0};
			quot_q     <= {quot_q[stb_pkg::PERIOD_W-2:0], ge};
			rem_q      <= ge ? stb_pkg::DIV_W'(shifted - {1'b0, div_eff})
			                 : shifted[stb_pkg::DIV_W-1:0];
			step_q     <= step_q + stb_pkg::STEP_W'(1);
		end
	end

endmodule

[hdl/prescaled_software_timer_bank_core.sv]
// A start, stop or busy-refused set passes the front register and the queue, then executes
// and registers its status; any other set first runs the 16-step restoring divider.
// A firing raw tick scans the 8 slots, one slot a cycle unless an expiry result stalls.
// Throughput: one item in execution at a time; the front register and 2-entry queue
// keep taking transfers while the back end works or the result waits, until they fill.
// Reset: all slots stopped with zero period and count, prescaler 0, tick_divider 20.
module prescaled_software_timer_bank_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  stb_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output stb_pkg::out_t             out_data,
	input  logic                      cfg_wr_en,
	input  logic [stb_pkg::DIV_W-1:0] cfg_wr_data
);

	logic [stb_pkg::DIV_W-1:0] tick_divider_q;
	logic                      push;
	stb_pkg::item_t            push_item;
	logic                      q_full;
	logic                      q_pop;
	logic                      q_valid;
	stb_pkg::item_t            q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_divider_q <= stb_pkg::DIVIDER_RESET;
		end else if (cfg_wr_en) begin
			tick_divider_q <= cfg_wr_data;
		end
	end

	stb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	stb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	stb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_divider (tick_divider_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule
